[hw/rtl/pxu_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxu_pkg: shared types and constants of the pixel unpacker
// Transaction payloads, configuration bundle, register and mode codes.
// ----------------------------------------------------------------------------
package pxu_pkg;

   localparam int PALETTE_ENTRIES = 256;
   localparam int PAL_IDX_W       = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
   localparam int PIXEL_BITS      = 32;
   localparam int CHANNEL_BITS    = 8;
   localparam int AMT_W           = $clog2(PIXEL_BITS + 1);
   localparam int CSR_ADDR_W      = 5;
   localparam int CSR_DATA_W      = 32;

   localparam logic ACTION_LOAD  = 1'b0;
   localparam logic ACTION_PIXEL = 1'b1;

   typedef enum logic [1:0] {
      MODE_GRAY    = 2'd0,
      MODE_PALETTE = 2'd1,
      MODE_DIRECT  = 2'd2
   } visual_mode_type;

   typedef enum logic [2:0] {
      REG_VISUAL_MODE     = 3'd0,
      REG_BYTES_PER_PIXEL = 3'd1,
      REG_MSB_FIRST       = 3'd2,
      REG_RED_SEL         = 3'd3,
      REG_GREEN_SEL       = 3'd4,
      REG_BLUE_SEL        = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic        action;
      logic [7:0]  byte0;
      logic [7:0]  byte1;
      logic [7:0]  byte2;
      logic [7:0]  byte3;
      logic [7:0]  map_index;
      logic [15:0] map_red;
      logic [15:0] map_green;
      logic [15:0] map_blue;
   } req_type;

   typedef struct packed {
      logic [7:0] red;
      logic [7:0] green;
      logic [7:0] blue;
   } rsp_type;

   // Shift amount per channel is trailing zeros plus popcount of the mask,
   // applied to the masked pixel with eight guard bits below it.
   typedef struct packed {
      logic [1:0]            visual_mode;
      logic [2:0]            bytes_per_pixel;
      logic                  msb_first;
      logic [PIXEL_BITS-1:0] red_sel;
      logic [PIXEL_BITS-1:0] green_sel;
      logic [PIXEL_BITS-1:0] blue_sel;
      logic [AMT_W-1:0]      red_amt;
      logic [AMT_W-1:0]      green_amt;
      logic [AMT_W-1:0]      blue_amt;
   } cfg_type;

endpackage
`default_nettype wire

[hw/rtl/pxu_csr.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxu_csr: configuration register file
// APB-style write and read of mode, byte layout and channel masks.
// ----------------------------------------------------------------------------
module pxu_csr
   import pxu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready,
   output cfg_type                    cfg
);

   function automatic logic [AMT_W-1:0] shift_amount(input logic [PIXEL_BITS-1:0] mask);
      logic [PIXEL_BITS-1:0] below;
      below = ~mask & (mask - PIXEL_BITS'(1));
      return AMT_W'($countones(below)) + AMT_W'($countones(mask));
   endfunction

   cfg_type    cfg_ff;
   cfg_type    cfg_in;
   logic       wr_en;
   logic [2:0] reg_idx;

   assign pready  = 1'b1;
   assign reg_idx = paddr[4:2];
   assign wr_en   = psel && penable && pwrite;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_VISUAL_MODE:     cfg_in.visual_mode     = pwdata[1:0];
            REG_BYTES_PER_PIXEL: cfg_in.bytes_per_pixel = pwdata[2:0];
            REG_MSB_FIRST:       cfg_in.msb_first       = pwdata[0];
            REG_RED_SEL: begin
               cfg_in.red_sel = pwdata;
               cfg_in.red_amt = shift_amount(pwdata);
            end
            REG_GREEN_SEL: begin
               cfg_in.green_sel = pwdata;
               cfg_in.green_amt = shift_amount(pwdata);
            end
            REG_BLUE_SEL: begin
               cfg_in.blue_sel = pwdata;
               cfg_in.blue_amt = shift_amount(pwdata);
            end
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_VISUAL_MODE:     prdata = {30'd0, cfg_ff.visual_mode};
         REG_BYTES_PER_PIXEL: prdata = {29'd0, cfg_ff.bytes_per_pixel};
         REG_MSB_FIRST:       prdata = {31'd0, cfg_ff.msb_first};
         REG_RED_SEL:         prdata = cfg_ff.red_sel;
         REG_GREEN_SEL:       prdata = cfg_ff.green_sel;
         REG_BLUE_SEL:        prdata = cfg_ff.blue_sel;
         default:             prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.visual_mode     <= MODE_GRAY;
         cfg_ff.bytes_per_pixel <= 3'd1;
         cfg_ff.msb_first       <= 1'b0;
         cfg_ff.red_sel         <= '0;
         cfg_ff.green_sel       <= '0;
         cfg_ff.blue_sel        <= '0;
         cfg_ff.red_amt         <= AMT_W'(PIXEL_BITS);
         cfg_ff.green_amt       <= AMT_W'(PIXEL_BITS);
         cfg_ff.blue_amt        <= AMT_W'(PIXEL_BITS);
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule
`default_nettype wire

[hw/rtl/pxu_palette.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxu_palette: palette memory
// One write port, one registered read port; valid bits make unwritten
// entries read as zero after reset.
// ----------------------------------------------------------------------------
module pxu_palette
   import pxu_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 wr_en,
   input  wire logic [PAL_IDX_W-1:0] wr_addr,
   input  wire logic [23:0]          wr_data,
   input  wire logic                 rd_en,
   input  wire logic [PAL_IDX_W-1:0] rd_addr,
   output logic      [23:0]          rd_data
);

   logic [23:0]                mem_ff [PALETTE_ENTRIES];
   logic [PALETTE_ENTRIES-1:0] valid_ff;
   logic [23:0]                rd_data_ff;
   logic                       rd_valid_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            valid_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_valid_ff <= valid_ff[rd_addr];
         end
      end
   end

   // Mask entries never written since reset.
   assign rd_data = rd_valid_ff ? rd_data_ff : 24'd0;

endmodule
`default_nettype wire

[hw/rtl/pixel_unpack_to_rgb888.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pixel_unpack_to_rgb888: raw pixel to RGB888 converter
// Assembles 1 to 4 raw bytes into a pixel and converts it to 8-bit red,
// green and blue by gray copy, palette lookup or mask-and-shift.
// ----------------------------------------------------------------------------
//
//  channel  ports            direction  content
//  -------  ---------------  ---------  ----------------------------------------
//  req      req_valid/stall  in         palette load or pixel (req_type)
//  rsp      rsp_valid/stall  out        converted pixel (rsp_type)
//  csr      psel..pready     in/out     mode, byte count, order, channel masks
//
//  One transaction per clock while req_stall is low. An accepted pixel
//  passes the palette memory read stage, then the channel select and shift
//  into the output register, from which it appears on rsp.
//  A palette load writes the memory in its accept cycle and gives no result.
//  Reset clears control state and the palette valid bits; no clearing pass.
//  rsp_stall holds the output register; the read stage still drains into it
//  when empty, and req_stall rises only when both stages are full.
// ----------------------------------------------------------------------------
module pixel_unpack_to_rgb888
   import pxu_pkg::*;
(
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_stall,
   input  wire req_type               req_data,
   output logic                       rsp_valid,
   input  wire logic                  rsp_stall,
   output rsp_type                    rsp_data,
   input  wire logic                  psel,
   input  wire logic                  penable,
   input  wire logic                  pwrite,
   input  wire logic [CSR_ADDR_W-1:0] paddr,
   input  wire logic [CSR_DATA_W-1:0] pwdata,
   output logic      [CSR_DATA_W-1:0] prdata,
   output logic                       pready
);

   // Mask the pixel, park it above eight guard bits, shift right by the
   // precomputed amount; this covers both right and left shifts.
   function automatic logic [7:0] extract(input logic [PIXEL_BITS-1:0] pixel,
                                          input logic [PIXEL_BITS-1:0] mask,
                                          input logic [AMT_W-1:0]      amt);
      logic [PIXEL_BITS+CHANNEL_BITS-1:0] wide;
      wide = {pixel & mask, 8'h00} >> amt;
      return wide[7:0];
   endfunction

   localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

   cfg_type               cfg;
   logic                  req_accept;
   logic                  out_move;
   logic                  s1_move;
   logic [1:0]            count_code;
   logic [PIXEL_BITS-1:0] pixel;
   logic                  pix_in_range;
   logic                  load_in_range;
   logic [23:0]           pal_rd_data;
   logic [23:0]           pal_wr_data;

   logic                  s1_valid_ff;
   logic                  s1_valid_in;
   logic [PIXEL_BITS-1:0] s1_pixel_ff;
   logic                  s1_in_range_ff;
   logic                  rsp_valid_ff;
   logic                  rsp_valid_in;
   rsp_type               rsp_data_ff;
   rsp_type               rsp_data_in;

   pxu_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   // Handshake: the output register parts the two sides.
   assign out_move   = !rsp_valid_ff || !rsp_stall;
   assign s1_move    = s1_valid_ff && out_move;
   assign req_stall  = s1_valid_ff && !out_move;
   assign req_accept = req_valid && !req_stall;

   // Clamp byte count to 1..4, coded as count minus one.
   always_comb begin
      if (cfg.bytes_per_pixel == 3'd0) begin
         count_code = 2'd0;
      end else if (cfg.bytes_per_pixel > 3'd4) begin
         count_code = 2'd3;
      end else begin
         count_code = 2'(cfg.bytes_per_pixel - 3'd1);
      end
   end

   always_comb begin
      if (!cfg.msb_first) begin
         unique case (count_code)
            2'd0: pixel = {24'd0, req_data.byte0};
            2'd1: pixel = {16'd0, req_data.byte1, req_data.byte0};
            2'd2: pixel = {8'd0, req_data.byte2, req_data.byte1, req_data.byte0};
            2'd3: pixel = {req_data.byte3, req_data.byte2, req_data.byte1, req_data.byte0};
         endcase
      end else begin
         unique case (count_code)
            2'd0: pixel = {24'd0, req_data.byte0};
            2'd1: pixel = {16'd0, req_data.byte0, req_data.byte1};
            2'd2: pixel = {8'd0, req_data.byte0, req_data.byte1, req_data.byte2};
            2'd3: pixel = {req_data.byte0, req_data.byte1, req_data.byte2, req_data.byte3};
         endcase
      end
   end

   assign pix_in_range  = {1'b0, pixel[7:0]} < PAL_LIMIT;
   assign load_in_range = {1'b0, req_data.map_index} < PAL_LIMIT;
   assign pal_wr_data   = {req_data.map_red[15:8], req_data.map_green[15:8],
                           req_data.map_blue[15:8]};

   // Loads write in their accept cycle; a pixel accepted next reads the
   // new entry, so no forwarding is needed.
   pxu_palette u_palette (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (req_accept && (req_data.action == ACTION_LOAD) && load_in_range),
      .wr_addr (req_data.map_index[PAL_IDX_W-1:0]),
      .wr_data (pal_wr_data),
      .rd_en   (req_accept && (req_data.action == ACTION_PIXEL)),
      .rd_addr (pixel[PAL_IDX_W-1:0]),
      .rd_data (pal_rd_data)
   );

   // Read stage: hold pixel beside the memory read.
   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (!s1_valid_ff || s1_move) begin
         s1_valid_in = req_accept && (req_data.action == ACTION_PIXEL);
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept && (req_data.action == ACTION_PIXEL)) begin
         s1_pixel_ff    <= pixel;
         s1_in_range_ff <= pix_in_range;
      end
   end

   // Convert from the read stage into the output register.
   always_comb begin
      rsp_data_in = '0;
      unique case (s1_valid_ff ? cfg.visual_mode : MODE_GRAY)
         MODE_GRAY: begin
            rsp_data_in.red   = s1_pixel_ff[7:0];
            rsp_data_in.green = s1_pixel_ff[7:0];
            rsp_data_in.blue  = s1_pixel_ff[7:0];
         end
         MODE_PALETTE: begin
            if (s1_in_range_ff) begin
               rsp_data_in.red   = pal_rd_data[23:16];
               rsp_data_in.green = pal_rd_data[15:8];
               rsp_data_in.blue  = pal_rd_data[7:0];
            end
         end
         MODE_DIRECT: begin
            rsp_data_in.red   = extract(s1_pixel_ff, cfg.red_sel, cfg.red_amt);
            rsp_data_in.green = extract(s1_pixel_ff, cfg.green_sel, cfg.green_amt);
            rsp_data_in.blue  = extract(s1_pixel_ff, cfg.blue_sel, cfg.blue_amt);
         end
         default: ;
      endcase
   end

   assign rsp_valid_in = out_move ? s1_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire

[hw/rtl/pxu_checker.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// pxu_checker: port-level checks of the pixel unpacker
// Watches the request, response and register ports over time.
// ----------------------------------------------------------------------------
module pxu_checker
   import pxu_pkg::*;
(
   input wire logic    clock,
   input wire logic    reset,
   input wire logic    req_valid,
   input wire logic    req_stall,
   input wire req_type req_data,
   input wire logic    rsp_valid,
   input wire logic    rsp_stall,
   input wire rsp_type rsp_data,
   input wire logic    psel,
   input wire logic    penable,
   input wire logic    pready
);

   // Hold a stalled result.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Stall requests only when the output holds a result and is blocked.
   a_req_stall: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled with room in the pipeline");

   // A new result traces back to an accepted pixel transaction through the read stage.
   a_rsp_origin: assert property (@(posedge clock) disable iff (reset)
      !$past(reset) && !$past(reset, 2) && $rose(rsp_valid) |->
         $past(req_valid && !req_stall && (req_data.action == ACTION_PIXEL), 2))
      else $error("response without a pixel transaction");

   // Drop all results on reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // Complete every register access with pready high in its access phase.
   a_csr_ready: assert property (@(posedge clock) disable iff (reset)
      psel && penable |-> pready)
      else $error("register access not ready");

endmodule

bind pixel_unpack_to_rgb888 pxu_checker u_pxu_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data),
   .psel      (psel),
   .penable   (penable),
   .pready    (pready)
);
`default_nettype wire
